@@ src/pfrf_pkg.sv @@
// Shared types, constants and a mask helper for the page framebuffer rectangle fill block.
`default_nettype none
package pfrf_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;
  localparam int PAGE_IDX_W  = 4;
  localparam int BIT_IDX_W   = 3;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef enum logic [2:0] {
    OP_FILL         = 3'd0,
    OP_SET_PIXEL    = 3'd1,
    OP_CLEAR_PIXEL  = 3'd2,
    OP_READ_BYTE    = 3'd3,
    OP_CLEAR_SCREEN = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_PIXEL,
    ST_READ,
    ST_RESULT
  } state_t;

  function automatic logic [7:0] page_mask(
    input logic [PAGE_IDX_W-1:0] pg,
    input logic [PAGE_IDX_W-1:0] first_pg,
    input logic [PAGE_IDX_W-1:0] last_pg,
    input logic [BIT_IDX_W-1:0]  y_low_bit,
    input logic [BIT_IDX_W-1:0]  y_high_bit
  );
    logic [7:0] mask;
    mask = BYTE_ONES;
    if (pg == first_pg) begin
      mask = mask & 8'(BYTE_ONES << y_low_bit);
    end
    if (pg == last_pg) begin
      if (y_high_bit == '0) begin
        mask = '0;
      end else begin
        mask = mask & 8'(BYTE_ONES >> (4'd8 - {1'b0, y_high_bit}));
      end
    end
    return mask;
  endfunction

endpackage
`default_nettype wire

@@ src/pfrf_ram.sv @@
// Single-port-write, single-port-read frame memory with registered read data.
`default_nettype none
module pfrf_ram
  import pfrf_pkg::*;
#(
  parameter int DEPTH = COLUMNS_DEF * PAGES_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/pfrf_ctrl.sv @@
// Command sequencer: walks rectangles and sweeps, and does read-modify-write on the frame memory.
`default_nettype none
module pfrf_ctrl
  import pfrf_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int PAGES   = PAGES_DEF,
  localparam int DEPTH  = COLUMNS * PAGES,
  localparam int ADDR_W = $clog2(DEPTH),
  localparam int COL_W  = $clog2(COLUMNS),
  localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire logic [2:0]        opcode,
  input  wire logic [6:0]        x_low,
  input  wire logic [5:0]        y_low,
  input  wire logic [7:0]        x_high,
  input  wire logic [6:0]        y_high,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output logic      [7:0]        read_data,
  output logic                   ram_we,
  output logic      [ADDR_W-1:0] ram_waddr,
  output logic      [7:0]        ram_wdata,
  output logic      [ADDR_W-1:0] ram_raddr,
  input  wire logic [7:0]        ram_rdata
);

  state_t state, state_next;

  logic [COL_W-1:0]      col, col_first, col_last;
  logic [PG_W-1:0]       pg, pg_last;
  logic [PAGE_IDX_W-1:0] first_pg, last_pg;
  logic [BIT_IDX_W-1:0]  y_low_bit, y_high_bit;
  logic                  pix_set;
  logic                  off_screen;
  logic                  wb_valid, wb_set;
  logic [7:0]            wb_mask;
  logic [ADDR_W-1:0]     wb_addr;

  logic [ADDR_W-1:0]     addr;
  logic                  last_elem;
  logic                  cmd_accept;
  logic                  x_on, pix_on, fill_ok, rsp_free, clearing;
  logic [8:0]            x_end;
  logic [PAGE_IDX_W-1:0] in_last_pg;
  logic [PG_W-1:0]       in_pg_last;
  logic [7:0]            merged;

  assign addr      = ADDR_W'(32'(pg) * COLUMNS + 32'(col));
  assign last_elem = (col == col_last) && (pg == pg_last);
  assign cmd_accept = cmd_valid && cmd_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  assign x_on    = {2'b00, x_low} < 9'(COLUMNS);
  assign pix_on  = x_on && ({2'b00, y_low[5:3]} < 5'(PAGES));
  assign fill_ok = x_on && (x_high > {1'b0, x_low}) && (y_high > {1'b0, y_low})
                   && ({2'b00, y_low[5:3]} < 5'(PAGES));
  assign x_end   = ({1'b0, x_high} > 9'(COLUMNS)) ? 9'(COLUMNS) : {1'b0, x_high};
  assign in_last_pg = y_high[6:3];
  assign in_pg_last = ({1'b0, in_last_pg} >= 5'(PAGES)) ? PG_W'(PAGES - 1)
                                                         : PG_W'(in_last_pg);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (last_elem) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (opcode)
            OP_FILL:         state_next = fill_ok ? ST_FILL : ST_IDLE;
            OP_SET_PIXEL,
            OP_CLEAR_PIXEL:  state_next = pix_on ? ST_PIXEL : ST_IDLE;
            OP_READ_BYTE:    state_next = pix_on ? ST_READ : ST_RESULT;
            OP_CLEAR_SCREEN: state_next = ST_CLEAR;
            default:         state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (last_elem) state_next = ST_IDLE;
      end
      ST_PIXEL:  state_next = ST_IDLE;
      ST_READ:   state_next = ST_RESULT;
      ST_RESULT: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    clearing  = 1'b0;
    unique case (state)
      ST_IDLE:  cmd_ready = 1'b1;
      ST_CLEAR: clearing  = 1'b1;
      default: begin
        cmd_ready = 1'b0;
        clearing  = 1'b0;
      end
    endcase
  end

  assign merged    = wb_set ? (ram_rdata | wb_mask) : (ram_rdata & ~wb_mask);
  assign ram_we    = clearing || wb_valid;
  assign ram_waddr = clearing ? addr : wb_addr;
  assign ram_wdata = clearing ? 8'h00 : merged;
  assign ram_raddr = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      col_first <= '0;
      col_last  <= COL_W'(COLUMNS - 1);
      pg        <= '0;
      pg_last   <= PG_W'(PAGES - 1);
      wb_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      wb_valid <= (state == ST_FILL) || (state == ST_PIXEL);

      if (state == ST_FILL || state == ST_CLEAR) begin
        if (col == col_last) begin
          col <= col_first;
          if (pg != pg_last) pg <= pg + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end else if (cmd_accept) begin
        unique case (opcode)
          OP_CLEAR_SCREEN: begin
            col       <= '0;
            col_first <= '0;
            col_last  <= COL_W'(COLUMNS - 1);
            pg        <= '0;
            pg_last   <= PG_W'(PAGES - 1);
          end
          OP_FILL: begin
            col       <= COL_W'(x_low);
            col_first <= COL_W'(x_low);
            col_last  <= COL_W'(x_end - 9'd1);
            pg        <= PG_W'(y_low[5:3]);
            pg_last   <= in_pg_last;
          end
          default: begin
            col <= COL_W'(x_low);
            pg  <= PG_W'(y_low[5:3]);
          end
        endcase
      end

      if (state == ST_RESULT && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      first_pg   <= {1'b0, y_low[5:3]};
      last_pg    <= in_last_pg;
      y_low_bit  <= y_low[2:0];
      y_high_bit <= y_high[2:0];
      pix_set    <= (opcode == OP_SET_PIXEL);
      off_screen <= !pix_on;
    end
    wb_addr <= addr;
    if (state == ST_FILL) begin
      wb_mask <= page_mask(PAGE_IDX_W'(pg), first_pg, last_pg, y_low_bit, y_high_bit);
      wb_set  <= 1'b1;
    end else begin
      wb_mask <= 8'(8'h01 << y_low_bit);
      wb_set  <= pix_set;
    end
    if (state == ST_RESULT && rsp_free) begin
      read_data <= off_screen ? 8'h00 : ram_rdata;
    end
  end

endmodule
`default_nettype wire

@@ src/page_framebuffer_rect_fill.sv @@
// Top level of the page-mode monochrome framebuffer with rectangle fill.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   command  | cmd_valid / cmd_ready  | opcode, x_low, y_low, x_high, y_high
//   response | rsp_valid / rsp_ready  | read_data (read byte only)
//
// Commands are accepted only while cmd_ready is high, in the idle state. A fill
// then walks every byte it touches and a clear sweeps all COLUMNS*PAGES bytes,
// and the frame memory does at most one read-modify-write per cycle. An on-screen
// pixel op does one read-modify-write and an on-screen read one memory read. After
// reset the block sweeps the whole memory (1024 bytes by default) to zero before
// cmd_ready rises. A pending response only stalls a read.
`default_nettype none
module page_framebuffer_rect_fill
  import pfrf_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int PAGES   = PAGES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire logic [2:0] opcode,
  input  wire logic [6:0] x_low,
  input  wire logic [5:0] y_low,
  input  wire logic [7:0] x_high,
  input  wire logic [6:0] y_high,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output logic      [7:0] read_data
);

  localparam int DEPTH  = COLUMNS * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  pfrf_ctrl #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .opcode   (opcode),
    .x_low    (x_low),
    .y_low    (y_low),
    .x_high   (x_high),
    .y_high   (y_high),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .read_data(read_data),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  pfrf_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the page framebuffer rectangle fill block.
`timescale 1ns / 1ps
module testbench;
  import pfrf_pkg::*;

  localparam int NUM_COLUMNS = COLUMNS_DEF;
  localparam int NUM_PAGES = PAGES_DEF;
  localparam int RESET_CYCLES = 7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1100;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS_PER_PHASE = 130;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] OP_UNUSED_LOW = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HIGH = 3'd7;

  class frame_mirror;
    logic [7:0] frame [NUM_COLUMNS*NUM_PAGES];
    logic [7:0] expected_reads[$];
    int mismatches;

    function new();
      mismatches = 0;
      foreach (frame[i]) frame[i] = '0;
    endfunction

    function void fill_rect(int xl, int yl, int xh, int yh);
      int xend;
      int first_pg;
      int last_pg;
      logic [7:0] mask;
      if (xh <= xl || yh <= yl) return;
      xend = (xh > NUM_COLUMNS) ? NUM_COLUMNS : xh;
      first_pg = yl >> 3;
      last_pg = yh >> 3;
      for (int p = first_pg; p <= last_pg && p < NUM_PAGES; p++) begin
        mask = 8'hFF;
        if (p == first_pg) mask = mask & 8'(8'hFF << (yl % 8));
        if (p == last_pg) mask = mask & 8'(8'hFF >> (8 - (yh % 8)));
        for (int x = xl; x < xend; x++) frame[p*NUM_COLUMNS + x] |= mask;
      end
    endfunction

    function void apply_command(logic [2:0] op, logic [6:0] xl, logic [5:0] yl,
                                logic [7:0] xh, logic [6:0] yh);
      int pg;
      int addr;
      logic [7:0] bitmask;
      pg = int'(yl) >> 3;
      addr = pg*NUM_COLUMNS + int'(xl);
      bitmask = 8'(8'h01 << yl[2:0]);
      case (op)
        OP_FILL: fill_rect(int'(xl), int'(yl), int'(xh), int'(yh));
        OP_SET_PIXEL: if (xl < NUM_COLUMNS && pg < NUM_PAGES) frame[addr] |= bitmask;
        OP_CLEAR_PIXEL: if (xl < NUM_COLUMNS && pg < NUM_PAGES) frame[addr] &= ~bitmask;
        OP_READ_BYTE: begin
          if (xl < NUM_COLUMNS && pg < NUM_PAGES) expected_reads.push_back(frame[addr]);
          else expected_reads.push_back('0);
        end
        OP_CLEAR_SCREEN: foreach (frame[i]) frame[i] = '0;
        default: ;
      endcase
    endfunction

    function void check_read_data(logic [7:0] got);
      logic [7:0] want;
      if (expected_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected read_data %02h with no read outstanding", got);
        return;
      end
      want = expected_reads.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("read_data mismatch: expected %02h, got %02h", want, got);
      end
    endfunction

    function int outstanding();
      return expected_reads.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  logic [2:0] opcode;
  logic [6:0] x_low;
  logic [5:0] y_low;
  logic [7:0] x_high;
  logic [6:0] y_high;
  logic rsp_valid;
  logic rsp_ready;
  logic [7:0] read_data;

  frame_mirror mirror = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int quiet_cycles = 0;

  page_framebuffer_rect_fill i_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .opcode(opcode),
    .x_low(x_low),
    .y_low(y_low),
    .x_high(x_high),
    .y_high(y_high),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .read_data(read_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready = 1'b0;
      end else begin
        rsp_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) mirror.check_read_data(read_data);
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(logic [2:0] op, logic [6:0] xl, logic [5:0] yl,
                          logic [7:0] xh, logic [6:0] yh);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    cmd_valid = 1'b1;
    opcode = op;
    x_low = xl;
    y_low = yl;
    x_high = xh;
    y_high = yh;
    do @(posedge clk); while (!cmd_ready);
    mirror.apply_command(op, xl, yl, xh, yh);
  endtask

  task automatic read_byte(logic [6:0] xl, logic [5:0] yl);
    send_cmd(OP_READ_BYTE, xl, yl, 8'($urandom), 7'($urandom));
  endtask

  task automatic send_random_fill();
    logic [6:0] xl;
    logic [5:0] yl;
    logic [7:0] xh;
    logic [6:0] yh;
    xl = 7'($urandom_range(127));
    yl = 6'($urandom_range(63));
    if ($urandom_range(9) == 0) begin
      xh = 8'($urandom);
      yh = 7'($urandom);
    end else begin
      xh = 8'(xl + $urandom_range(12));
      yh = 7'(yl + $urandom_range(20));
    end
    send_cmd(OP_FILL, xl, yl, xh, yh);
  endtask

  task automatic run_random(int count);
    int issued;
    int sel;
    issued = 0;
    while (issued < count) begin
      sel = $urandom_range(99);
      issued++;
      if (sel < 35) begin
        read_byte(7'($urandom), 6'($urandom));
      end else if (sel < 62) begin
        send_random_fill();
      end else if (sel < 78) begin
        send_cmd(OP_SET_PIXEL, 7'($urandom), 6'($urandom), 8'($urandom), 7'($urandom));
      end else if (sel < 92) begin
        send_cmd(OP_CLEAR_PIXEL, 7'($urandom), 6'($urandom), 8'($urandom),
                 7'($urandom));
      end else if (sel < 95) begin
        send_cmd(OP_CLEAR_SCREEN, 7'($urandom), 6'($urandom), 8'($urandom),
                 7'($urandom));
      end else begin
        issued--;
        send_cmd(3'($urandom_range(OP_UNUSED_LOW, OP_UNUSED_HIGH)), 7'($urandom),
                 6'($urandom), 8'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    opcode = OP_FILL;
    x_low = '0;
    y_low = '0;
    x_high = '0;
    y_high = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    read_byte(7'd0, 6'd0);
    read_byte(7'd127, 6'd63);
    send_cmd(OP_SET_PIXEL, 7'd127, 6'd63, 8'd0, 7'd0);
    read_byte(7'd127, 6'd63);
    send_cmd(OP_CLEAR_PIXEL, 7'd127, 6'd63, 8'd255, 7'd127);
    read_byte(7'd127, 6'd63);
    send_cmd(OP_FILL, 7'd0, 6'd0, 8'd128, 7'd64);
    read_byte(7'd0, 6'd0);
    read_byte(7'd127, 6'd56);
    send_cmd(OP_CLEAR_SCREEN, 7'd0, 6'd0, 8'd0, 7'd0);
    read_byte(7'd64, 6'd32);
    send_cmd(OP_FILL, 7'd10, 6'd3, 8'd10, 7'd20);
    send_cmd(OP_FILL, 7'd10, 6'd20, 8'd20, 7'd3);
    read_byte(7'd10, 6'd3);
    send_cmd(OP_FILL, 7'd20, 6'd3, 8'd22, 7'd6);
    read_byte(7'd21, 6'd0);
    send_cmd(OP_FILL, 7'd30, 6'd8, 8'd31, 7'd16);
    read_byte(7'd30, 6'd8);
    read_byte(7'd30, 6'd16);
    send_cmd(OP_FILL, 7'd120, 6'd45, 8'd255, 7'd127);
    read_byte(7'd127, 6'd40);
    send_cmd(OP_UNUSED_LOW, 7'd40, 6'd9, 8'd50, 7'd30);
    send_cmd(OP_UNUSED_MID, 7'd40, 6'd9, 8'd50, 7'd30);
    send_cmd(OP_UNUSED_HIGH, 7'd40, 6'd9, 8'd50, 7'd30);
    read_byte(7'd40, 6'd9);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 62; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 62; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      run_random(RANDOM_ITEMS_PER_PHASE);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (int i = 0; i < 12; i++) read_byte(7'($urandom), 6'($urandom));

    @(negedge clk);
    cmd_valid = 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
